// File: src/svm_pkg.sv
// ============================================================================
// svm_pkg: shared types and constants of the stereo voice mixer
// Holds the item and format codes, register indexes, controller states and
// the command and status bundles passed between controller and datapath.
// ============================================================================
package svm_pkg;

  // Item modes.
  localparam logic [1:0] MODE_VOICE8  = 2'd0;
  localparam logic [1:0] MODE_VOICE16 = 2'd1;
  localparam logic [1:0] MODE_CLOSE   = 2'd2;

  // Output sample formats.
  localparam logic [1:0] FMT_S16 = 2'd0;
  localparam logic [1:0] FMT_U8  = 2'd1;
  localparam logic [1:0] FMT_S8  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MASTER_VOLUME   = 2'd0;
  localparam logic [1:0] REG_SAMPLE_FORMAT   = 2'd1;
  localparam logic [1:0] REG_OUTPUT_CHANNELS = 2'd2;

  // Channel count that selects mono output.
  localparam logic [1:0] CHANNELS_MONO = 2'd1;

  // Register reset values.
  localparam logic [8:0] MASTER_VOLUME_RESET   = 9'd179;
  localparam logic [1:0] SAMPLE_FORMAT_RESET   = FMT_S16;
  localparam logic [1:0] OUTPUT_CHANNELS_RESET = 2'd2;

  // Datapath widths: gain is unsigned, the product is signed.
  localparam int GAIN_W = 17;
  localparam int OP_W   = 17;
  localparam int MUL_W  = OP_W + GAIN_W + 1;
  localparam int CLIP_W = 24;
  localparam int MIX_W  = 26;

  // Frame-close clip range and 16-bit output range.
  localparam int MIX_HI = 32767 * 256;
  localparam int MIX_LO = -32768 * 256;
  localparam logic signed [17:0] OUT_HI = 18'sd32767;
  localparam logic signed [17:0] OUT_LO = -18'sd32768;
  localparam logic signed [15:0] U8_BIAS = 16'sd128;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_MUL,
    ST_ACC,
    ST_MIX,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;
    logic gain;
    logic mul;
    logic acc;
    logic mix;
    logic emit;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// File: src/svm_ctrl.sv
// ============================================================================
// svm_ctrl: sequencing controller of the stereo voice mixer
// Steps each accepted voice item through gain, multiply and accumulate, or
// a frame close through mix and emit, and drives the datapath commands.
// ============================================================================
module svm_ctrl
  import svm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] mode,
  output logic       in_stall,
  input  status_t    status,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && (state == ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_VOICE8 || mode == MODE_VOICE16) begin
            state_next = ST_GAIN;
          end else if (mode == MODE_CLOSE) begin
            state_next = ST_MIX;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_GAIN: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = ST_IDLE;
      ST_MIX:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = accept;
      end
      ST_GAIN: cmd.gain = 1'b1;
      ST_MUL:  cmd.mul  = 1'b1;
      ST_ACC:  cmd.acc  = 1'b1;
      ST_MIX:  cmd.mix  = 1'b1;
      ST_EMIT: cmd.emit = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// File: src/svm_dp.sv
// ============================================================================
// svm_dp: datapath of the stereo voice mixer
// Holds the configuration registers, the captured item, one gain and one
// multiply lane per side, the saturating accumulators and the output register.
// ============================================================================
module svm_dp
  import svm_pkg::*;
#(
  parameter int ACC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic [1:0]         mode,
  input  logic signed [15:0] sample,
  input  logic [7:0]         left_volume,
  input  logic [7:0]         right_volume,
  input  logic signed [23:0] music_left,
  input  logic signed [23:0] music_right,
  input  logic               music_valid,
  input  cmd_t               cmd,
  output status_t            status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right
);

  localparam int SUM_W = ((ACC_BITS > MUL_W) ? ACC_BITS : MUL_W) + 1;
  localparam logic signed [SUM_W-1:0] ACC_HI =
    SUM_W'((64'sd1 <<< (ACC_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - SUM_W'(1);
  localparam logic signed [ACC_BITS-1:0] CLIP_HI = ACC_BITS'(MIX_HI);
  localparam logic signed [ACC_BITS-1:0] CLIP_LO = ACC_BITS'(MIX_LO);

  // Configuration registers.
  logic [8:0] master_volume;
  logic [1:0] sample_format;
  logic [1:0] output_channels;

  // Captured item.
  logic [1:0]         item_mode;
  logic signed [15:0] item_sample;
  logic [7:0]         item_lv;
  logic [7:0]         item_rv;
  logic signed [23:0] item_ml;
  logic signed [23:0] item_mr;

  // Lanes, accumulators and mix results.
  logic [GAIN_W-1:0]         gain_l;
  logic [GAIN_W-1:0]         gain_r;
  logic signed [OP_W-1:0]    op;
  logic signed [MUL_W-1:0]   prod_l;
  logic signed [MUL_W-1:0]   prod_r;
  logic signed [ACC_BITS-1:0] left_acc;
  logic signed [ACC_BITS-1:0] right_acc;
  logic signed [MIX_W-1:0]   mix_l;
  logic signed [MIX_W-1:0]   mix_r;

  logic [GAIN_W-1:0]          gain_l_next;
  logic [GAIN_W-1:0]          gain_r_next;
  logic signed [OP_W-1:0]     op_next;
  logic signed [ACC_BITS-1:0] left_acc_next;
  logic signed [ACC_BITS-1:0] right_acc_next;
  logic signed [MIX_W-1:0]    mix_l_next;
  logic signed [MIX_W-1:0]    mix_r_next;
  logic signed [15:0]         out_left_next;
  logic signed [15:0]         out_right_next;

  // Saturating accumulate of one lane.
  function automatic logic signed [ACC_BITS-1:0] acc_add(
    input logic signed [ACC_BITS-1:0] a,
    input logic signed [MUL_W-1:0]    d
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(d);
    if (s > ACC_HI) begin
      s = ACC_HI;
    end else if (s < ACC_LO) begin
      s = ACC_LO;
    end
    return s[ACC_BITS-1:0];
  endfunction

  // Clip the accumulator to the frame range and add the music sample.
  function automatic logic signed [MIX_W-1:0] mix_side(
    input logic signed [ACC_BITS-1:0] a,
    input logic signed [23:0]         music
  );
    logic signed [ACC_BITS-1:0] c;
    c = a;
    if (c > CLIP_HI) begin
      c = CLIP_HI;
    end else if (c < CLIP_LO) begin
      c = CLIP_LO;
    end
    return MIX_W'(signed'(c[CLIP_W-1:0])) + MIX_W'(music);
  endfunction

  // Shift down, saturate to 16 bits and apply the output format.
  function automatic logic signed [15:0] format_side(
    input logic signed [MIX_W-1:0] m,
    input logic [1:0]              fmt
  );
    logic signed [17:0] v;
    logic signed [15:0] s16;
    logic signed [15:0] s8;
    v = m[MIX_W-1:8];
    if (v > OUT_HI) begin
      v = OUT_HI;
    end else if (v < OUT_LO) begin
      v = OUT_LO;
    end
    s16 = v[15:0];
    s8  = 16'(signed'(s16[15:8]));
    case (fmt)
      FMT_U8:  return s8 + U8_BIAS;
      FMT_S8:  return s8;
      default: return s16;
    endcase
  endfunction

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume   <= MASTER_VOLUME_RESET;
      sample_format   <= SAMPLE_FORMAT_RESET;
      output_channels <= OUTPUT_CHANNELS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MASTER_VOLUME:   master_volume   <= cfg_data;
        REG_SAMPLE_FORMAT:   sample_format   <= cfg_data[1:0];
        REG_OUTPUT_CHANNELS: output_channels <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted item; music counts only when present.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode   <= mode;
      item_sample <= sample;
      item_lv     <= left_volume;
      item_rv     <= right_volume;
      item_ml     <= music_valid ? music_left : 24'sd0;
      item_mr     <= music_valid ? music_right : 24'sd0;
    end
  end

  // Gain stage: an 8-bit voice uses the coarse volume times master,
  // a 16-bit voice uses volume times master scaled down by 256.
  always_comb begin
    logic [16:0] pl;
    logic [16:0] pr;
    if (item_mode == MODE_VOICE8) begin
      pl = 17'({item_lv[7:3], 3'b000}) * 17'(master_volume);
      pr = 17'({item_rv[7:3], 3'b000}) * 17'(master_volume);
      gain_l_next = pl;
      gain_r_next = pr;
      op_next = OP_W'(signed'(item_sample[7:0]));
    end else begin
      pl = 17'(item_lv) * 17'(master_volume);
      pr = 17'(item_rv) * 17'(master_volume);
      gain_l_next = GAIN_W'(pl[16:8]);
      gain_r_next = GAIN_W'(pr[16:8]);
      op_next = OP_W'(item_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      gain_l <= gain_l_next;
      gain_r <= gain_r_next;
      op     <= op_next;
    end
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_l <= MUL_W'(op * signed'({1'b0, gain_l}));
      prod_r <= MUL_W'(op * signed'({1'b0, gain_r}));
    end
  end

  // Accumulators: saturating add, cleared when a frame is emitted.
  always_comb begin
    left_acc_next  = left_acc;
    right_acc_next = right_acc;
    if (cmd.emit) begin
      left_acc_next  = '0;
      right_acc_next = '0;
    end else if (cmd.acc) begin
      left_acc_next  = acc_add(left_acc, prod_l);
      right_acc_next = acc_add(right_acc, prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_acc  <= '0;
      right_acc <= '0;
    end else begin
      left_acc  <= left_acc_next;
      right_acc <= right_acc_next;
    end
  end

  // Mix stage of a frame close.
  assign mix_l_next = mix_side(left_acc, item_ml);
  assign mix_r_next = mix_side(right_acc, item_mr);

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      mix_l <= mix_l_next;
      mix_r <= mix_r_next;
    end
  end

  // Output register; the right side reads zero in mono.
  assign out_left_next  = format_side(mix_l, sample_format);
  assign out_right_next = (output_channels == CHANNELS_MONO) ? 16'sd0 :
                          format_side(mix_r, sample_format);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_left  <= out_left_next;
      out_right <= out_right_next;
    end
  end

  assign status.out_busy = out_valid && out_stall;

endmodule

// File: src/stereo_voice_mixer.sv
// ============================================================================
// stereo_voice_mixer: sums the voices of one stereo frame and emits it
//
// Input channel (in_valid / in_stall) carries one item per transaction: a
// voice sample to add (8-bit or 16-bit mode) or a frame close with its
// optional music pair. A voice item steps through accept, gain, multiply
// and accumulate; a close steps through accept, mix and emit, and out_valid
// rises as the emit step loads the output register. The controller runs one
// item at a time through a gain multiplier and a sample multiplier per side
// and stalls input outside idle. Unused-mode items are accepted and dropped.
// Output channel (out_valid / out_stall) delivers one formatted frame per
// close from an output register. While the receiver stalls, voice items are
// still taken; a further close waits in its emit step until the held frame
// has left. Configuration writes (cfg_write, cfg_index, cfg_data) take effect
// at once and belong in idle periods. Reset clears both accumulators, drops
// any pending output and restores master volume 179, signed 16-bit format
// and stereo output.
// ============================================================================
module stereo_voice_mixer
  import svm_pkg::*;
#(
  parameter int ACC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [15:0] sample,
  input  logic [7:0]         left_volume,
  input  logic [7:0]         right_volume,
  input  logic signed [23:0] music_left,
  input  logic signed [23:0] music_right,
  input  logic               music_valid,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right
);

  cmd_t    cmd;
  status_t status;

  // Sequencing controller.
  svm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic datapath.
  svm_dp #(
    .ACC_BITS (ACC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .sample       (sample),
    .left_volume  (left_volume),
    .right_volume (right_volume),
    .music_left   (music_left),
    .music_right  (music_right),
    .music_valid  (music_valid),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left     (out_left),
    .out_right    (out_right)
  );

endmodule
